@@ hdl/fte_pkg.sv @@
`default_nettype none

package fte_pkg;

  localparam int SIZE     = 1024;
  localparam int OP_W     = 2;
  localparam int IN_IDX_W = 10;
  localparam int DATA_W   = 64;
  localparam int ADDR_W   = $clog2(SIZE);
  localparam int K_W      = $clog2(SIZE + 1) + 1;
  localparam int TOP_BIT  = $clog2(SIZE + 2) - 1;

  typedef enum logic [OP_W-1:0] {
    OP_ADD    = 2'd0,
    OP_SET    = 2'd1,
    OP_RANGE  = 2'd2,
    OP_SEARCH = 2'd3
  } op_t;

  typedef enum logic [3:0] {
    ST_CLR,
    ST_IDLE,
    ST_WALK_RD,
    ST_WALK_ACC,
    ST_ADD_RD,
    ST_ADD_WR,
    ST_SRCH_RD,
    ST_SRCH_CMP,
    ST_DONE
  } state_t;

  function automatic logic [K_W-1:0] low_bit(input logic [K_W-1:0] k);
    return k & (~k + K_W'(1));
  endfunction

  function automatic logic [K_W-1:0] clamp_idx(input logic [IN_IDX_W-1:0] idx);
    logic [K_W-1:0] wide;
    wide = K_W'(idx);
    if (wide >= K_W'(SIZE)) begin
      wide = K_W'(SIZE - 1);
    end
    return wide;
  endfunction

endpackage

`default_nettype wire

@@ hdl/fenwick_tree_engine.sv @@
`default_nettype none

// Binary indexed tree over 1024 signed 64-bit counters, held in a single-port-write,
// single-port-read memory with registered read data; one sequencer walks the tree one
// cell at a time through 64-bit adders and a signed comparator. After reset the store
// is cleared cell by cell, and no item is taken during the pass. Each tree cell is
// read, then accumulated, written back or compared: add walks up the tree, a range sum
// takes up to two prefix walks, set value a prefix walk pair followed by an add, and
// prefix search halves its step down to one. Adds and sets give no result; queries give
// one answer, which may wait in the output register while the next item is taken.
module fenwick_tree_engine (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic [fte_pkg::OP_W-1:0]     in_operation,
  input  wire logic [fte_pkg::IN_IDX_W-1:0] in_index,
  input  wire logic [fte_pkg::IN_IDX_W-1:0] in_index_high,
  input  wire logic signed [fte_pkg::DATA_W-1:0] in_value,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic signed [fte_pkg::DATA_W-1:0] out_answer
);

  import fte_pkg::*;

  logic [DATA_W-1:0] mem [SIZE];
  logic [DATA_W-1:0] rdata_r;
  logic [ADDR_W-1:0] rd_addr;
  logic [ADDR_W-1:0] wr_addr;
  logic [DATA_W-1:0] wr_data;
  logic              wr_en;

  state_t            state_r, state_nxt;
  op_t               op_r, op_nxt;
  logic [DATA_W-1:0] val_r, val_nxt;
  logic [DATA_W-1:0] acc_r, acc_nxt;
  logic [K_W-1:0]    k_r, k_nxt;
  logic [K_W-1:0]    lo_r, lo_nxt;
  logic              sub_r, sub_nxt;
  logic [K_W-1:0]    pos_r, pos_nxt;
  logic [K_W-1:0]    step_r, step_nxt;
  logic [ADDR_W-1:0] clr_r, clr_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [DATA_W-1:0] answer_r, answer_nxt;

  logic              in_fire;
  logic [K_W-1:0]    idx_c;
  logic [K_W-1:0]    hi_c;
  logic [K_W-1:0]    next_pos;
  logic [DATA_W-1:0] trial;

  assign in_stall   = (state_r != ST_IDLE);
  assign in_fire    = in_valid && !in_stall;
  assign out_valid  = out_valid_r;
  assign out_answer = answer_r;
  assign idx_c      = clamp_idx(in_index);
  assign hi_c       = clamp_idx(in_index_high);
  assign next_pos   = pos_r + step_r;
  assign trial      = acc_r + rdata_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rdata_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
    end
    op_r     <= op_nxt;
    val_r    <= val_nxt;
    acc_r    <= acc_nxt;
    k_r      <= k_nxt;
    lo_r     <= lo_nxt;
    sub_r    <= sub_nxt;
    pos_r    <= pos_nxt;
    step_r   <= step_nxt;
    answer_r <= answer_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    val_nxt       = val_r;
    acc_nxt       = acc_r;
    k_nxt         = k_r;
    lo_nxt        = lo_r;
    sub_nxt       = sub_r;
    pos_nxt       = pos_r;
    step_nxt      = step_r;
    clr_nxt       = clr_r;
    answer_nxt    = answer_r;
    out_valid_nxt = out_valid_r && out_stall;
    rd_addr       = '0;
    wr_addr       = '0;
    wr_data       = '0;
    wr_en         = 1'b0;

    case (state_r)
      ST_CLR: begin
        wr_en   = 1'b1;
        wr_addr = clr_r;
        clr_nxt = clr_r + ADDR_W'(1);
        if (clr_r == ADDR_W'(SIZE - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_fire) begin
          op_nxt  = op_t'(in_operation);
          val_nxt = in_value;
          acc_nxt = '0;
          sub_nxt = 1'b0;
          case (op_t'(in_operation))
            OP_ADD: begin
              k_nxt     = idx_c + K_W'(1);
              state_nxt = ST_ADD_RD;
            end
            OP_SET: begin
              k_nxt     = idx_c + K_W'(1);
              lo_nxt    = idx_c;
              state_nxt = ST_WALK_RD;
            end
            OP_RANGE: begin
              k_nxt     = hi_c + K_W'(1);
              lo_nxt    = idx_c;
              state_nxt = ST_WALK_RD;
            end
            OP_SEARCH: begin
              pos_nxt   = '0;
              step_nxt  = K_W'(1) << TOP_BIT;
              state_nxt = ST_SRCH_RD;
            end
            default: state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_WALK_RD: begin
        rd_addr = ADDR_W'(k_r - K_W'(1));
        if (k_r != '0) begin
          state_nxt = ST_WALK_ACC;
        end else if (!sub_r && lo_r != '0) begin
          k_nxt   = lo_r;
          sub_nxt = 1'b1;
        end else if (op_r == OP_SET) begin
          val_nxt   = val_r - acc_r;
          k_nxt     = lo_r + K_W'(1);
          state_nxt = ST_ADD_RD;
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_WALK_ACC: begin
        acc_nxt   = sub_r ? (acc_r - rdata_r) : trial;
        k_nxt     = k_r - low_bit(k_r);
        state_nxt = ST_WALK_RD;
      end
      ST_ADD_RD: begin
        rd_addr = ADDR_W'(k_r - K_W'(1));
        if (k_r > K_W'(SIZE)) begin
          state_nxt = ST_IDLE;
        end else begin
          state_nxt = ST_ADD_WR;
        end
      end
      ST_ADD_WR: begin
        wr_en     = 1'b1;
        wr_addr   = ADDR_W'(k_r - K_W'(1));
        wr_data   = rdata_r + val_r;
        k_nxt     = k_r + low_bit(k_r);
        state_nxt = ST_ADD_RD;
      end
      ST_SRCH_RD: begin
        rd_addr = ADDR_W'(next_pos - K_W'(1));
        if (next_pos < K_W'(SIZE)) begin
          k_nxt     = next_pos;
          state_nxt = ST_SRCH_CMP;
        end else begin
          step_nxt = step_r >> 1;
          if (step_r == K_W'(1)) begin
            state_nxt = ST_DONE;
          end
        end
      end
      ST_SRCH_CMP: begin
        if ($signed(trial) < $signed(val_r)) begin
          acc_nxt = trial;
          pos_nxt = k_r;
        end
        step_nxt = step_r >> 1;
        if (step_r == K_W'(1)) begin
          state_nxt = ST_DONE;
        end else begin
          state_nxt = ST_SRCH_RD;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          answer_nxt    = (op_r == OP_SEARCH) ? DATA_W'(pos_r) : acc_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

`default_nettype wire
